FILE: rtl/core/spcq_pkg.sv
package spcq_pkg;

  // Defaults for the top-level parameters
  localparam int LEVELS_DEF      = 4;
  localparam int DEPTH_DEF       = 16;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed field widths of the command and result words
  localparam int FUNC_W   = 2;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: rtl/core/spcq_if.sv
interface spcq_in_if #(
  parameter int HANDLE_BITS = spcq_pkg::HANDLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [spcq_pkg::FUNC_W-1:0]   func;
  logic [spcq_pkg::PRIO_W-1:0]   prio;
  logic [HANDLE_BITS-1:0]        handle;

  modport source (output valid, output func, output prio, output handle, input ready);
  modport sink   (input valid, input func, input prio, input handle, output ready);
endinterface

interface spcq_out_if #(
  parameter int HANDLE_BITS = spcq_pkg::HANDLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [spcq_pkg::STATUS_W-1:0] status;
  logic [HANDLE_BITS-1:0]        popped_handle;
  logic [spcq_pkg::LEVEL_W-1:0]  popped_level;
  logic                          pending;

  modport source (output valid, output status, output popped_handle, output popped_level,
                  output pending, input ready);
  modport sink   (input valid, input status, input popped_handle, input popped_level,
                  input pending, output ready);
endinterface

FILE: rtl/core/spcq_ptr_unit.sv
// Shared pointer/count unit: advance a ring index and step a fill count.
module spcq_ptr_unit #(
  parameter int DEPTH = spcq_pkg::DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic [IDX_W-1:0] ptr,
  input  logic [CNT_W-1:0] cnt,
  input  logic             dec,
  output logic [IDX_W-1:0] ptr_nxt,
  output logic [CNT_W-1:0] cnt_nxt,
  output logic             full
);

  assign ptr_nxt = (ptr == IDX_W'(DEPTH - 1)) ? '0 : ptr + IDX_W'(1);
  assign cnt_nxt = dec ? cnt - CNT_W'(1) : cnt + CNT_W'(1);
  assign full    = (cnt >= CNT_W'(DEPTH));

endmodule

FILE: rtl/core/spcq_slot_ram.sv
// Slot store: one write port, one registered read port.
module spcq_slot_ram #(
  parameter int ENTRIES = spcq_pkg::LEVELS_DEF * spcq_pkg::DEPTH_DEF,
  parameter int WIDTH   = spcq_pkg::HANDLE_BITS_DEF,
  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/strict_priority_command_queue.sv
// Strict-priority command queue: LEVELS FIFOs of DEPTH handles each, held in one
// single-port-write/registered-read slot RAM, with per-level head, tail and fill
// count registers. Each command word is handled in an accept step and a result step: in the accept cycle the
// level is chosen (push: prio, saturated to LEVELS-1; pop: lowest non-empty
// level), the shared pointer unit advances that level's tail or head and count,
// and the RAM is written (push) or read (pop); in the result step the RAM read
// data arrives and, once the output register is free, the result word is loaded into it. in ready
// is high only between items: no new word is accepted before the last one's result
// has been loaded into the output register. The output register lets the next word be
// accepted while a result still waits. Push to a full level returns status full
// and drops the handle; pop on an empty queue returns status empty; clear resets
// all pointers without touching the RAM. pending reports any level non-empty
// after the step. No clearing pass is needed after reset.
module strict_priority_command_queue #(
  parameter int LEVELS      = spcq_pkg::LEVELS_DEF,
  parameter int DEPTH       = spcq_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = spcq_pkg::HANDLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  spcq_in_if.sink          in_ch,
  spcq_out_if.source       out_ch
);

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ENTRIES = LEVELS * DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DONE = 1'b1;

  logic state_r;

  // Per-level ring state
  logic [IDX_W-1:0] head_r [LEVELS];
  logic [IDX_W-1:0] tail_r [LEVELS];
  logic [CNT_W-1:0] cnt_r  [LEVELS];

  // Result of the step, held until the RAM data returns
  logic [spcq_pkg::STATUS_W-1:0] op_status_r;
  logic [LVL_W-1:0]              op_level_r;
  logic                          op_pop_ok_r;

  // Output register
  logic                          out_valid_r;
  logic [spcq_pkg::STATUS_W-1:0] out_status_r;
  logic [HANDLE_BITS-1:0]        out_handle_r;
  logic [spcq_pkg::LEVEL_W-1:0]  out_level_r;
  logic                          out_pending_r;

  logic             accept;
  logic             is_push;
  logic             is_pop;
  logic             is_clear;
  logic [LEVELS-1:0] nonempty;
  logic             pop_found;
  logic [LVL_W-1:0] pop_lvl;
  logic [LVL_W-1:0] push_lvl;
  logic [LVL_W-1:0] sel_lvl;
  logic [IDX_W-1:0] ptr_in;
  logic [IDX_W-1:0] ptr_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic             lvl_full;
  logic             push_ok;
  logic             pop_ok;
  logic [ADDR_W-1:0] slot_addr;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic             load_out;
  logic             cnt_over;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_push  = (in_ch.func == spcq_pkg::OP_PUSH);
  assign is_pop   = (in_ch.func == spcq_pkg::OP_POP);
  assign is_clear = (in_ch.func == spcq_pkg::OP_CLEAR);

  // Find the lowest non-empty level for pop
  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    cnt_over  = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      nonempty[l] = (cnt_r[l] != '0);
      cnt_over    = cnt_over || (cnt_r[l] > CNT_W'(DEPTH));
      if (nonempty[l]) begin
        pop_found = 1'b1;
        pop_lvl   = LVL_W'(l);
      end
    end
  end

  // Saturate the push level to the top level present
  assign push_lvl = (int'(in_ch.prio) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(in_ch.prio);

  assign sel_lvl = is_push ? push_lvl : pop_lvl;
  assign ptr_in  = is_push ? tail_r[sel_lvl] : head_r[sel_lvl];

  spcq_ptr_unit #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .ptr     (ptr_in),
    .cnt     (cnt_r[sel_lvl]),
    .dec     (!is_push),
    .ptr_nxt (ptr_nxt),
    .cnt_nxt (cnt_nxt),
    .full    (lvl_full)
  );

  assign push_ok   = accept && is_push && !lvl_full;
  assign pop_ok    = accept && is_pop && pop_found;
  assign slot_addr = ADDR_W'(sel_lvl) * ADDR_W'(DEPTH) + ADDR_W'(ptr_in);

  spcq_slot_ram #(
    .ENTRIES (ENTRIES),
    .WIDTH   (HANDLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (slot_addr),
    .wdata (in_ch.handle),
    .re    (pop_ok),
    .raddr (slot_addr),
    .rdata (ram_rdata)
  );

  // Advance the selected level's pointers; clear drops every level at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (accept && is_clear) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else if (push_ok) begin
      tail_r[sel_lvl] <= ptr_nxt;
      cnt_r[sel_lvl]  <= cnt_nxt;
    end else if (pop_ok) begin
      head_r[sel_lvl] <= ptr_nxt;
      cnt_r[sel_lvl]  <= cnt_nxt;
    end
  end

  // Hold the step outcome until the read data is back
  always_ff @(posedge clk) begin
    if (accept) begin
      op_pop_ok_r <= pop_ok;
      op_level_r  <= pop_ok ? pop_lvl : '0;
      if (is_push && lvl_full) begin
        op_status_r <= spcq_pkg::ST_FULL;
      end else if (is_pop && !pop_found) begin
        op_status_r <= spcq_pkg::ST_EMPTY;
      end else begin
        op_status_r <= spcq_pkg::ST_OK;
      end
    end
  end

  // Load the result word once the output register is free
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r  <= op_status_r;
      out_handle_r  <= op_pop_ok_r ? ram_rdata : '0;
      out_level_r   <= spcq_pkg::LEVEL_W'(op_level_r);
      out_pending_r <= |nonempty;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.popped_handle = out_handle_r;
  assign out_ch.popped_level  = out_level_r;
  assign out_ch.pending       = out_pending_r;

  // An accepted word always moves the sequencer to wait for its result
  a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DONE))
    else $error("sequencer did not advance after accept");

  // No level ever holds more than DEPTH handles
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_over)
    else $error("fill count beyond depth");

  // A pop that found nothing must report nothing pending
  a_empty_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == spcq_pkg::ST_EMPTY)) |-> !out_pending_r)
    else $error("empty pop reported pending");

endmodule
